// ===== hw/rtl/rgb565_box_downsample_4x4_core_assert.svh =====
// Assertion macros used by the port-level checks in rbd_core_chk.
`ifndef RGB565_BOX_DOWNSAMPLE_4X4_CORE_ASSERT_SVH
`define RGB565_BOX_DOWNSAMPLE_4X4_CORE_ASSERT_SVH

// same-cycle implication
`define RBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Constants and types of the 4x4 RGB565 box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int OUT_WIDTH  = 40;
  localparam int OUT_HEIGHT = 30;
  localparam int SRC_WIDTH  = 160;
  localparam int SRC_HEIGHT = 120;

  localparam int GRID_COLS = 4 * OUT_WIDTH;
  localparam int GRID_ROWS = 4 * OUT_HEIGHT;

  localparam int COL_W = $clog2(SRC_WIDTH);
  localparam int ROW_W = $clog2(SRC_HEIGHT);
  localparam int OX_W  = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
  localparam int OY_W  = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;

  localparam int PIX_W   = 16;
  localparam int OCOL_W  = 6;
  localparam int OROW_W  = 5;
  localparam int SUM_W   = 12;
  localparam int ACC_W   = 3 * SUM_W;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } acc_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              done;
  } res_t;

endpackage

// ===== hw/rtl/rgb565_box_downsample_4x4_core.sv =====
// ----------------------------------------------------------------------------
// rgb565_box_downsample_4x4_core
// Averages every 4x4 block of an RGB565 raster stream into one RGB565 pixel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_stall is low. A closing pixel's request
// is formed from the stage-1 registers and held in the output register or
// skid entry. Column sums live in a one-port-read RAM, one entry per output
// column; the read issued at accept is merged in the next cycle with a
// forwarded copy of the last write, so adjacent pixels of a block update the
// same entry without a bubble. An output register plus a skid entry absorb
// downstream stalls; in_stall rises only while the skid entry is occupied.
module rgb565_box_downsample_4x4_core
  import rbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_pixel_out,
  output logic [OCOL_W-1:0] out_col,
  output logic [OROW_W-1:0] out_row,
  output logic              out_frame_done
);

  logic             in_acc;
  logic [COL_W-1:0] src_col_r, src_col_nxt;
  logic [ROW_W-1:0] src_row_r, src_row_nxt;
  logic             in_grid;
  logic [OX_W-1:0]  ox;
  logic [OY_W-1:0]  oy;
  logic [7:0]       r8, g8, b8;

  logic             s1_valid_r;
  logic             s1_first_r, s1_last_r;
  logic [OX_W-1:0]  s1_ox_r;
  logic [OY_W-1:0]  s1_oy_r;
  logic [7:0]       s1_r8_r, s1_g8_r, s1_b8_r;

  acc_t             ram_rd;
  acc_t             base, sum;
  logic             wb_valid_r;
  logic [OX_W-1:0]  wb_addr_r;
  acc_t             wb_data_r;

  logic [SUM_W:0]   avg_r, avg_g, avg_b;
  logic             emit;
  res_t             emit_res;
  logic             out_free;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;
  logic             skid_valid_r, skid_valid_nxt;
  res_t             skid_res_r;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  // source position and pixel widening
  assign in_grid = (32'(src_col_r) < GRID_COLS) && (32'(src_row_r) < GRID_ROWS);
  assign ox      = OX_W'(src_col_r >> 2);
  assign oy      = OY_W'(src_row_r >> 2);
  assign r8      = {in_pixel_in[15:11], in_pixel_in[15:13]};
  assign g8      = {in_pixel_in[10:5], in_pixel_in[10:9]};
  assign b8      = {in_pixel_in[4:0], in_pixel_in[4:2]};

  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    if (in_acc) begin
      if (src_col_r == COL_W'(SRC_WIDTH - 1)) begin
        src_col_nxt = '0;
        if (src_row_r == ROW_W'(SRC_HEIGHT - 1)) begin
          src_row_nxt = '0;
        end else begin
          src_row_nxt = src_row_r + ROW_W'(1);
        end
      end else begin
        src_col_nxt = src_col_r + COL_W'(1);
      end
    end
  end

  rbd_ram #(
    .WIDTH (ACC_W),
    .DEPTH (OUT_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_ox_r),
    .wdata (sum),
    .re    (in_acc && in_grid),
    .raddr (ox),
    .rdata (ram_rd)
  );

  // read-modify-write with forwarding of the previous cycle's write
  always_comb begin
    base = ram_rd;
    if (wb_valid_r && (wb_addr_r == s1_ox_r)) begin
      base = wb_data_r;
    end
    if (s1_first_r) begin
      sum.r = {4'b0, s1_r8_r};
      sum.g = {4'b0, s1_g8_r};
      sum.b = {4'b0, s1_b8_r};
    end else begin
      sum.r = base.r + {4'b0, s1_r8_r};
      sum.g = base.g + {4'b0, s1_g8_r};
      sum.b = base.b + {4'b0, s1_b8_r};
    end
  end

  assign avg_r = {1'b0, sum.r} + (SUM_W+1)'(8);
  assign avg_g = {1'b0, sum.g} + (SUM_W+1)'(8);
  assign avg_b = {1'b0, sum.b} + (SUM_W+1)'(8);

  assign emit           = s1_valid_r && s1_last_r;
  assign emit_res.pixel = {avg_r[11:7], avg_g[11:6], avg_b[11:7]};
  assign emit_res.col   = OCOL_W'(s1_ox_r);
  assign emit_res.row   = OROW_W'(s1_oy_r);
  assign emit_res.done  = (s1_ox_r == OX_W'(OUT_WIDTH - 1)) &&
                          (s1_oy_r == OY_W'(OUT_HEIGHT - 1));

  // output register and skid entry
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = emit;
      end else begin
        out_valid_nxt = emit;
      end
    end else if (emit) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r    <= '0;
      src_row_r    <= '0;
      s1_valid_r   <= 1'b0;
      wb_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      src_col_r    <= src_col_nxt;
      src_row_r    <= src_row_nxt;
      s1_valid_r   <= in_acc && in_grid;
      wb_valid_r   <= s1_valid_r;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_first_r <= (src_col_r[1:0] == 2'd0) && (src_row_r[1:0] == 2'd0);
      s1_last_r  <= (src_col_r[1:0] == 2'd3) && (src_row_r[1:0] == 2'd3);
      s1_ox_r    <= ox;
      s1_oy_r    <= oy;
      s1_r8_r    <= r8;
      s1_g8_r    <= g8;
      s1_b8_r    <= b8;
    end
    wb_addr_r <= s1_ox_r;
    wb_data_r <= sum;
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : emit_res;
    end
    if ((out_free && skid_valid_r && emit) || (!out_free && emit)) begin
      skid_res_r <= emit_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_res_r.pixel;
  assign out_col        = out_res_r.col;
  assign out_row        = out_res_r.row;
  assign out_frame_done = out_res_r.done;

endmodule

// ===== hw/rtl/rbd_ram.sv =====
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rbd_core_chk.sv =====
// ----------------------------------------------------------------------------
// rbd_core_chk
// Port-level checks of the 4x4 box downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb565_box_downsample_4x4_core_assert.svh"

module rbd_core_chk
  import rbd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [PIX_W-1:0]  in_pixel_in,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PIX_W-1:0]  out_pixel_out,
  input logic [OCOL_W-1:0] out_col,
  input logic [OROW_W-1:0] out_row,
  input logic              out_frame_done
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall && (in_pixel_in == in_pixel_in);

  `RBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pixel_out) && $stable(out_col) && $stable(out_row) && $stable(out_frame_done), "stalled request changed")
  `RBD_ASSERT_NOW(a_done_pos, out_valid && out_frame_done, (out_col == OCOL_W'(OUT_WIDTH - 1)) && (out_row == OROW_W'(OUT_HEIGHT - 1)), "frame_done away from last block")
  `RBD_ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_acc, 2), "request without a closing pixel")
  `RBD_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "input stall without output stall")

endmodule

bind rgb565_box_downsample_4x4_core rbd_core_chk u_rbd_core_chk (.*);

// ===== bench/rgb565_box_downsample_4x4_core_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb565_box_downsample_4x4_core_checker
// Watches both channels of the 4x4 box downsampler. Every accepted source
// pixel is folded into a private set of column sums; each closed block queues
// the averaged pixel, which is compared field by field with the next request
// leaving the block.
// ----------------------------------------------------------------------------
module rgb565_box_downsample_4x4_core_checker
  import rbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [PIX_W-1:0]  out_pixel_out,
  input  logic [OCOL_W-1:0] out_col,
  input  logic [OROW_W-1:0] out_row,
  input  logic              out_frame_done,
  output int                fail_count,
  output int                pending
);

  acc_t col_sums [OUT_WIDTH];
  int   src_x;
  int   src_y;
  res_t blocks_due [$];

  function automatic logic [7:0] box_mean(logic [SUM_W-1:0] s);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(8);
    return t[11:4];
  endfunction

  task automatic compare_field(string label, logic [15:0] expected, logic [15:0] actual);
    if (expected !== actual) begin
      fail_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, label, expected, actual);
    end
  endtask

  task automatic fold_pixel(logic [PIX_W-1:0] px);
    logic [7:0] r8, g8, b8;
    logic [7:0] r_avg, g_avg, b_avg;
    int ox, oy;
    res_t blk;
    r8 = {px[15:11], px[15:13]};
    g8 = {px[10:5], px[10:9]};
    b8 = {px[4:0], px[4:2]};
    if (src_x < GRID_COLS && src_y < GRID_ROWS) begin
      ox = src_x / 4;
      oy = src_y / 4;
      // block start overwrites the column sum
      if (src_x % 4 == 0 && src_y % 4 == 0) begin
        col_sums[ox].r = SUM_W'(r8);
        col_sums[ox].g = SUM_W'(g8);
        col_sums[ox].b = SUM_W'(b8);
      end else begin
        col_sums[ox].r = col_sums[ox].r + SUM_W'(r8);
        col_sums[ox].g = col_sums[ox].g + SUM_W'(g8);
        col_sums[ox].b = col_sums[ox].b + SUM_W'(b8);
      end
      if (src_x % 4 == 3 && src_y % 4 == 3) begin
        r_avg = box_mean(col_sums[ox].r);
        g_avg = box_mean(col_sums[ox].g);
        b_avg = box_mean(col_sums[ox].b);
        blk.pixel = {r_avg[7:3], g_avg[7:2], b_avg[7:3]};
        blk.col = OCOL_W'(ox);
        blk.row = OROW_W'(oy);
        blk.done = (ox == OUT_WIDTH - 1 && oy == OUT_HEIGHT - 1);
        blocks_due.push_back(blk);
      end
    end
    src_x++;
    if (src_x >= SRC_WIDTH) begin
      src_x = 0;
      src_y++;
      if (src_y >= SRC_HEIGHT) src_y = 0;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      src_x = 0;
      src_y = 0;
      blocks_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (blocks_due.size() == 0) begin
          fail_count++;
          $display("%0t unexpected request: expected none actual pixel %h col %0d row %0d",
                   $time, out_pixel_out, out_col, out_row);
        end else begin
          want = blocks_due.pop_front();
          compare_field("pixel_out", want.pixel, out_pixel_out);
          compare_field("out_col", 16'(want.col), 16'(out_col));
          compare_field("out_row", 16'(want.row), 16'(out_row));
          compare_field("frame_done", 16'(want.done), 16'(out_frame_done));
        end
      end
      if (in_valid && !in_stall) fold_pixel(in_pixel_in);
    end
    pending = blocks_due.size();
  end

endmodule

// ===== bench/rgb565_box_downsample_4x4_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb565_box_downsample_4x4_core_test
// Feeds a few corner pixels, then the first block rows of a frame with
// block-wise color bands and noise, under random idling on both sides and
// one long output hold-off. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module rgb565_box_downsample_4x4_core_test;
  import rbd_pkg::*;

  localparam int DIRECTED_PIXELS = 20;
  localparam int TOTAL_PIXELS    = 1650;
  localparam int CALM_PIXELS     = 300;
  localparam int HOLD_CYCLES     = 400;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel_in;
  logic              out_valid;
  logic              out_stall;
  logic [PIX_W-1:0]  out_pixel_out;
  logic [OCOL_W-1:0] out_col;
  logic [OROW_W-1:0] out_row;
  logic              out_frame_done;
  int                fail_count;
  int                pending;

  int sent = 0;
  bit calm = 0;
  bit holding = 0;
  bit hold_done = 0;

  logic [PIX_W-1:0] band_color [OUT_WIDTH];
  logic [PIX_W-1:0] band_noise [OUT_WIDTH];

  rgb565_box_downsample_4x4_core u_top (.*);

  rgb565_box_downsample_4x4_core_checker u_check (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("rgb565_box_downsample_4x4_core_test NOT OK");
    $finish;
  end

  function automatic logic [PIX_W-1:0] corner_pixel(int i);
    case (i)
      0:  return 16'h0000;
      1:  return 16'hffff;
      2:  return 16'hf800;
      3:  return 16'h07e0;
      4:  return 16'h001f;
      5:  return 16'haaaa;
      6:  return 16'h5555;
      7:  return 16'h0821;
      8:  return 16'h8410;
      9:  return 16'h7bef;
      10: return 16'hffe0;
      11: return 16'hf81f;
      12: return 16'h07ff;
      13: return 16'h0001;
      14: return 16'h8000;
      15: return 16'h0020;
      16: return 16'h0800;
      17: return 16'h0010;
      18: return 16'h0400;
      default: return 16'hffff;
    endcase
  endfunction

  // source side
  initial begin
    int total, gap_pct, x, y;
    logic [PIX_W-1:0] px;
    bit drained;
    total = TOTAL_PIXELS;
    gap_pct = 0;
    drained = 0;
    rst_n <= 0;
    in_valid <= 0;
    in_pixel_in <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (sent < total) begin
      x = sent % SRC_WIDTH;
      y = (sent / SRC_WIDTH) % SRC_HEIGHT;
      // new colors per output column at the top of each block row
      if (x == 0 && y % 4 == 0) begin
        for (int ox = 0; ox < OUT_WIDTH; ox++) begin
          case ($urandom_range(0, 4))
            0: band_color[ox] = '0;
            1: band_color[ox] = '1;
            default: band_color[ox] = PIX_W'($urandom);
          endcase
          case ($urandom_range(0, 3))
            0: band_noise[ox] = '0;
            1: band_noise[ox] = 16'h0821;
            2: band_noise[ox] = 16'h18e3;
            default: band_noise[ox] = '1;
          endcase
        end
      end
      if (sent % 128 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 12;
          default: gap_pct = 50;
        endcase
      end
      calm = (sent >= total - CALM_PIXELS);
      if (sent < DIRECTED_PIXELS) px = corner_pixel(sent);
      else if ($urandom_range(0, 9) == 0) px = PIX_W'($urandom);
      else px = band_color[x / 4] ^ (PIX_W'($urandom) & band_noise[x / 4]);
      if (!calm && !holding && $urandom_range(0, 99) < gap_pct) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      in_valid <= 1;
      in_pixel_in <= px;
      do @(posedge clk); while (in_stall);
      sent++;
    end
    in_valid <= 0;
    repeat (5000) begin
      @(negedge clk);
      if (pending == 0) begin
        drained = 1;
        break;
      end
    end
    if (!drained) begin
      $display("rgb565_box_downsample_4x4_core_test NOT OK");
      $finish;
    end else begin
      repeat (20) @(negedge clk);
      if (fail_count == 0) begin
        $display("rgb565_box_downsample_4x4_core_test OK");
      end else begin
        $display("rgb565_box_downsample_4x4_core_test NOT OK");
      end
      $finish;
    end
  end

  // result side; one long hold-off once requests are flowing
  initial begin
    out_stall <= 0;
    @(posedge clk);
    forever begin
      if (!calm && !hold_done && sent >= 700 && out_valid) begin
        holding = 1;
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 0;
        hold_done = 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_ram.sv
hw/rtl/rgb565_box_downsample_4x4_core.sv
hw/rtl/rbd_core_chk.sv
bench/rgb565_box_downsample_4x4_core_checker.sv
bench/rgb565_box_downsample_4x4_core_test.sv
